// ===== sv/decaying_sine_tone_generator_defines.svh =====
// Assertion macros for the decaying sine tone generator.
// Used by modules that check their own sequencing; needs clk and rst_n in scope.
`ifndef DECAYING_SINE_TONE_GENERATOR_DEFINES_SVH
`define DECAYING_SINE_TONE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define DSTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define DSTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSTG_ASSERT(lbl, prop, msg)
`define DSTG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/dstg_pkg.sv =====
// Package for the decaying sine tone generator: constants, register map,
// control structs and the sine table generator. No dependencies.
package dstg_pkg;

    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_BITS_DEF  = 32;

    localparam int TONE_W    = 24;
    localparam int ENV_W     = 25;
    localparam int ENV_Q15_W = 16;
    localparam int ENV_SHIFT = 9;
    localparam int OUT_W     = 16;
    localparam int REG_W     = 32;
    localparam int APB_ADDR_W = 4;

    localparam int P_SHIFT    = 15;
    localparam int GAIN_SHIFT = 16;
    localparam int GAIN_W     = 17;

    // 2*pi in Q2.30, 1.0 in Q2.30, 0.35 in Q0.16, envelope 1.0 in Q1.24
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30    = 64'd1073741824;
    localparam logic signed [GAIN_W-1:0] GAIN_035 = 17'sd22938;
    localparam logic [ENV_W-1:0] ENV_ONE = 25'h1000000;

    localparam logic [TONE_W-1:0] TONE_LENGTH_RST = 24'd1;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_PHASE_INC  = 2'd0;
    localparam logic [1:0] REG_TONE_LEN   = 2'd1;
    localparam logic [1:0] REG_DECAY_STEP = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

    // sine of q/2^tb of a turn, q in 0..2^(tb-2), Q2.30, truncated Taylor series
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] q, input int tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        logic signed [63:0] sum;
        int k;
        x = (q * TWO_PI_Q30) >> tb;
        x2 = (x * x) >> 30;
        term = x;
        sum = 64'sd0;
        for (k = 1; k <= 7; k++)
        begin
            if (k[0])
                sum = sum + $signed(term);
            else
                sum = sum - $signed(term);
            prod = (term * x2) >> 30;
            case (k)
                1: term = prod / 64'd6;
                2: term = prod / 64'd20;
                3: term = prod / 64'd42;
                4: term = prod / 64'd72;
                5: term = prod / 64'd110;
                6: term = prod / 64'd156;
                7: term = prod / 64'd210;
                default: term = prod;
            endcase
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > $signed(ONE_Q30))
            sum = $signed(ONE_Q30);
        return $unsigned(sum);
    endfunction

    // table entry idx: round(sin(2*pi*idx/2^tb) * (2^(sb-1)-1)) via quarter-wave symmetry
    function automatic logic signed [31:0] sine_entry(input logic [63:0] idx, input int tb,
                                                      input int sb);
        logic [63:0] quarter;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] amp;
        logic [63:0] mag;
        logic [63:0] s;
        quarter = 64'd1 << (tb - 2);
        quad = (idx >> (tb - 2)) & 64'd3;
        r = idx & (quarter - 64'd1);
        if (quad[0])
            r = quarter - r;
        s = quarter_sine_q30(r, tb);
        amp = (64'd1 << (sb - 1)) - 64'd1;
        mag = (s * amp + (64'd1 << 29)) >> 30;
        if (quad[1])
            return -$signed(mag[31:0]);
        return $signed(mag[31:0]);
    endfunction

endpackage

// ===== sv/dstg_state_mem.sv =====
// Single-entry state memory of the tone generator, registered read.
// Depends on dstg_pkg for the access control struct.
module dstg_state_mem #(
    parameter int WIDTH = 82
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dstg_pkg::mem_ctrl_t ctrl,
    input  logic [WIDTH-1:0]   wdata,
    output logic [WIDTH-1:0]   rdata
);
    import dstg_pkg::*;

    logic [WIDTH-1:0] mem [0:0];
    logic             valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    // entry reads as zero (idle) until first written after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.wr_en)
            valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[0] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            if (ctrl.wr_en)
                rdata_reg <= wdata;
            else if (valid_reg)
                rdata_reg <= mem[0];
            else
                rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dstg_sine_rom.sv =====
// Sine lookup ROM, 2^TABLE_BITS entries of signed SAMPLE_BITS, registered read.
// Contents generated at elaboration by dstg_pkg::sine_entry.
module dstg_sine_rom #(
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic [TABLE_BITS-1:0]         addr,
    output logic signed [SAMPLE_BITS-1:0] data
);
    import dstg_pkg::*;

    localparam int DEPTH = 1 << TABLE_BITS;

    logic signed [SAMPLE_BITS-1:0] rom_word [DEPTH];
    logic signed [SAMPLE_BITS-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam logic signed [SAMPLE_BITS-1:0] ENTRY =
            SAMPLE_BITS'(sine_entry(64'(i), TABLE_BITS, SAMPLE_BITS));
        assign rom_word[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_word[addr];
    end

    assign data = data_reg;

endmodule

// ===== sv/dstg_engine.sv =====
// Tick sequencer: reads the state word, updates it and writes it back while the tone runs,
// runs the shared multiplier twice and holds the result frame. Uses dstg_pkg and the defines.
`include "decaying_sine_tone_generator_defines.svh"

module dstg_engine #(
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 32,
    parameter int STATE_W     = PHASE_BITS + 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dstg_pkg::OUT_W-1:0]    sample,
    output logic                          last,
    output logic                          active,
    input  logic [PHASE_BITS-1:0]         phase_increment,
    input  logic [dstg_pkg::TONE_W-1:0]   tone_length,
    input  logic [dstg_pkg::ENV_W-1:0]    decay_step,
    output dstg_pkg::mem_ctrl_t           mem_ctrl,
    output logic [STATE_W-1:0]            mem_wdata,
    input  logic [STATE_W-1:0]            mem_rdata,
    output logic [TABLE_BITS-1:0]         rom_addr,
    input  logic signed [SAMPLE_BITS-1:0] rom_data
);
    import dstg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam int A_W    = SAMPLE_BITS + 2;
    localparam int PROD_W = A_W + GAIN_W;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       restart_reg;
    logic       accept;

    logic [PHASE_BITS-1:0] rd_phase;
    logic [TONE_W-1:0]     rd_frame;
    logic [ENV_W-1:0]      rd_env;
    logic                  rd_run;

    logic [PHASE_BITS-1:0] cur_phase;
    logic [TONE_W-1:0]     cur_frame;
    logic [ENV_W-1:0]      cur_env;
    logic                  cur_run;
    logic [TONE_W-1:0]     last_idx;
    logic                  is_last;
    logic [ENV_W-1:0]      env_next;
    logic [TONE_W-1:0]     frame_next;

    logic                  run_reg;
    logic                  is_last_reg;
    logic [ENV_Q15_W-1:0]  env_q15_reg;

    logic signed [A_W-1:0]    mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_sample_reg;
    logic             out_last_reg;
    logic             out_active_reg;
    logic             out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // state word: {running, envelope, frame, phase}
    assign {rd_run, rd_env, rd_frame, rd_phase} = mem_rdata;

    always_comb
    begin
        cur_run   = rd_run || restart_reg;
        cur_phase = restart_reg ? '0 : rd_phase;
        cur_frame = restart_reg ? '0 : rd_frame;
        cur_env   = restart_reg ? ENV_ONE : rd_env;
        last_idx  = (tone_length == '0) ? '0 : tone_length - TONE_W'(1);
        is_last   = (cur_frame == last_idx);
        env_next  = (cur_env > decay_step) ? cur_env - decay_step : '0;
        frame_next = is_last ? cur_frame : cur_frame + TONE_W'(1);
    end

    assign rom_addr       = cur_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign mem_ctrl.rd_en = accept;
    assign mem_ctrl.wr_en = (state_reg == S_READ) && cur_run;
    assign mem_wdata      = {!is_last, env_next, frame_next, cur_phase + phase_increment};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            restart_reg <= restart;
        if (state_reg == S_READ)
        begin
            run_reg     <= cur_run;
            is_last_reg <= is_last;
            env_q15_reg <= cur_env[ENV_W-1:ENV_SHIFT];
        end
    end

    // shared multiplier: sine * envelope first, then p * 0.35
    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mul_a = A_W'(rom_data);
            mul_b = $signed({1'b0, env_q15_reg});
        end
        else
        begin
            mul_a = A_W'(prod_reg >>> P_SHIFT);
            mul_b = GAIN_035;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1 || state_reg == S_MUL2)
            prod_reg <= PROD_W'(mul_a * mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= run_reg ? OUT_W'(prod_reg >>> GAIN_SHIFT) : '0;
            out_last_reg   <= run_reg && is_last_reg;
            out_active_reg <= run_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = out_sample_reg;
    assign last      = out_last_reg;
    assign active    = out_active_reg;

    `DSTG_ASSERT(a_idle_frame_zero, (out_valid_reg && !out_active_reg) |-> (out_sample_reg == '0 && !out_last_reg), "idle frame carries sample or last")
    `DSTG_ASSERT(a_wb_in_read, mem_ctrl.wr_en |-> (state_reg == S_READ), "state write outside read step")
    `DSTG_ASSERT_NEXT(a_accept_reads, accept, (state_reg == S_READ), "accepted tick did not start a read")
    `DSTG_ASSERT_NEXT(a_out_held, (state_reg == S_OUT && out_valid_reg && !out_ready), (state_reg == S_OUT && out_valid_reg), "pending frame overwritten")

endmodule

// ===== sv/decaying_sine_tone_generator.sv =====
// Top level of the decaying sine tone generator: APB register file and block wiring.
// Depends on dstg_pkg, dstg_state_mem, dstg_sine_rom and dstg_engine.
//
//   channel   | kind          | payload
//   ----------+---------------+-------------------------------------------------
//   s_axis    | stream in     | tdata[0] restart
//   m_axis    | stream out    | tdata left/right sample, tlast, tuser active
//   apb       | register port | phase_increment, tone_length, decay_step
//
// After acceptance a tick passes through a state memory read, two passes through
// the shared multiplier, then the output load and the return to idle. A new tick
// is accepted only from idle, after the previous one is done. The next tick is
// accepted while a result waits; it stalls in the output step only if the previous
// frame is still untaken. Reset is asynchronous; the state entry reads as idle
// until its first write, so no clearing pass is needed.
module decaying_sine_tone_generator #(
    parameter int TABLE_BITS  = dstg_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = dstg_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = dstg_pkg::PHASE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [0] restart
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,   // [15:0] left, [31:16] right
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser,   // [0] active
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dstg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dstg_pkg::REG_W-1:0]       pwdata,
    output logic [dstg_pkg::REG_W-1:0]       prdata,
    output logic                             pready
);
    import dstg_pkg::*;

    localparam int STATE_W = PHASE_BITS + TONE_W + ENV_W + 1;

    logic [REG_W-1:0]  phase_inc_reg;
    logic [TONE_W-1:0] tone_len_reg;
    logic [ENV_W-1:0]  decay_step_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    mem_ctrl_t                     mem_ctrl;
    logic [STATE_W-1:0]            mem_wdata;
    logic [STATE_W-1:0]            mem_rdata;
    logic [TABLE_BITS-1:0]         rom_addr;
    logic signed [SAMPLE_BITS-1:0] rom_data;
    logic [OUT_W-1:0]              sample;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg  <= '0;
            tone_len_reg   <= TONE_LENGTH_RST;
            decay_step_reg <= ENV_ONE;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_PHASE_INC:  phase_inc_reg  <= pwdata;
                REG_TONE_LEN:   tone_len_reg   <= pwdata[TONE_W-1:0];
                REG_DECAY_STEP: decay_step_reg <= pwdata[ENV_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PHASE_INC:  prdata = phase_inc_reg;
            REG_TONE_LEN:   prdata = REG_W'(tone_len_reg);
            REG_DECAY_STEP: prdata = REG_W'(decay_step_reg);
            default:        prdata = '0;
        endcase
    end

    dstg_state_mem #(
        .WIDTH (STATE_W)
    ) u_state_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mem_ctrl),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    dstg_sine_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    dstg_engine #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .STATE_W     (STATE_W)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .restart         (s_axis_tdata[0]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .sample          (sample),
        .last            (m_axis_tlast),
        .active          (m_axis_tuser),
        .phase_increment (phase_inc_reg[PHASE_BITS-1:0]),
        .tone_length     (tone_len_reg),
        .decay_step      (decay_step_reg),
        .mem_ctrl        (mem_ctrl),
        .mem_wdata       (mem_wdata),
        .mem_rdata       (mem_rdata),
        .rom_addr        (rom_addr),
        .rom_data        (rom_data)
    );

    assign m_axis_tdata = {sample, sample};

endmodule
